// ----- rtl/core/modular_exponentiation_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Modular exponentiation unit - assertion macros
// Shared concurrent assertion forms. Each expects signals named clk and rst
// in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define MEXP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mexp assertion failed (same-cycle check)");

// Next-cycle implication, off during reset
`define MEXP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mexp assertion failed (next-cycle check)");

`endif

// ----- rtl/core/mexp_pkg.sv -----
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Widths, reset constants, controller states and the command/status
// bundles shared by the controller and the datapath.
// ---------------------------------------------------------------------------
package mexp_pkg;

  // Field and datapath widths
  localparam int unsigned MEXP_MOD_W      = 32;
  localparam int unsigned MEXP_FIELD_W    = 63;
  localparam int unsigned MEXP_PROD_W     = 2 * MEXP_MOD_W;
  localparam int unsigned MEXP_EXP_BITS   = 63;
  localparam int unsigned MEXP_IN_DATA_W  = 128;
  localparam int unsigned MEXP_OUT_DATA_W = 32;

  localparam logic [MEXP_MOD_W-1:0] MEXP_RESET_MODULUS = 32'd1000000007;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE_R,
    ST_BASE_W,
    ST_CHECK,
    ST_BIT,
    ST_MUL_P,
    ST_MUL_R,
    ST_MUL_W,
    ST_SQR_P,
    ST_SQR_R,
    ST_SQR_W,
    ST_DONE
  } mexp_state_t;

  // Accumulator load source
  typedef enum logic [1:0] {
    ACC_ZERO,
    ACC_ONE,
    ACC_BASE,
    ACC_REM
  } mexp_acc_src_t;

  // Remainder unit dividend source
  typedef enum logic {
    RED_BASE,
    RED_PROD
  } mexp_red_src_t;

  // Multiplier operand pairing
  typedef enum logic {
    MUL_ACC_B,
    MUL_B_B
  } mexp_mul_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic          load_in;
    logic          mul_go;
    mexp_mul_sel_t mul_sel;
    logic          red_go;
    mexp_red_src_t red_src;
    logic          acc_we;
    mexp_acc_src_t acc_src;
    logic          base_we;
    logic          exp_shift;
    logic          out_load;
  } mexp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic mod_zero;
    logic red_done;
    logic base_le1;
    logic exp_zero;
    logic exp_lsb;
    logic exp_rest_zero;
  } mexp_status_t;

endpackage

// ----- rtl/core/mexp_modred.sv -----
// ---------------------------------------------------------------------------
// Modular exponentiation - bit-serial remainder unit
// Reduces a 64-bit dividend modulo a 32-bit modulus by restoring division,
// one dividend bit per cycle. Pulses done when the remainder is ready.
// ---------------------------------------------------------------------------
module mexp_modred (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [mexp_pkg::MEXP_PROD_W-1:0] dividend,
  input  logic [mexp_pkg::MEXP_MOD_W-1:0]  modulus,
  output logic                             done,
  output logic [mexp_pkg::MEXP_MOD_W-1:0]  remainder
);
  import mexp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MEXP_PROD_W);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [MEXP_PROD_W-1:0] dvd;
  logic [MEXP_MOD_W-1:0] rem;
  logic [MEXP_MOD_W:0]   trial;
  logic [MEXP_MOD_W:0]   diff;
  logic [MEXP_MOD_W-1:0] rem_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, dvd[MEXP_PROD_W-1]};
    diff     = trial - {1'b0, modulus};
    rem_next = diff[MEXP_MOD_W] ? trial[MEXP_MOD_W-1:0] : diff[MEXP_MOD_W-1:0];
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(MEXP_PROD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Dividend shifter and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[MEXP_PROD_W-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ----- rtl/core/mexp_datapath.sv -----
// ---------------------------------------------------------------------------
// Modular exponentiation - datapath
// Modulus register, operand registers, the shared 32x32 multiplier with its
// product register, the remainder unit and the output data register.
// ---------------------------------------------------------------------------
module mexp_datapath #(
  parameter int unsigned EXP_BITS = mexp_pkg::MEXP_EXP_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mexp_pkg::mexp_cmd_t                  cmd,
  output mexp_pkg::mexp_status_t               status,
  input  logic [mexp_pkg::MEXP_FIELD_W-1:0]    base,
  input  logic [mexp_pkg::MEXP_FIELD_W-1:0]    exponent,
  input  logic                                 cfg_we,
  input  logic [mexp_pkg::MEXP_MOD_W-1:0]      cfg_data,
  output logic [mexp_pkg::MEXP_OUT_DATA_W-1:0] power_mod
);
  import mexp_pkg::*;

  localparam int unsigned EXT_W = MEXP_FIELD_W + 1;

  logic [MEXP_MOD_W-1:0]   modulus;
  logic [MEXP_FIELD_W-1:0] base_raw;
  logic [EXP_BITS-1:0]     expo;
  logic [MEXP_MOD_W-1:0]   b;
  logic [MEXP_MOD_W-1:0]   acc;
  logic [MEXP_PROD_W-1:0]  prod;
  logic [MEXP_MOD_W-1:0]   mul_a;
  logic [MEXP_PROD_W-1:0]  red_dividend;
  logic [MEXP_MOD_W-1:0]   rem;
  logic                    red_done;
  logic [EXT_W-1:0]        exp_ext;

  assign exp_ext = {1'b0, exponent};

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MEXP_RESET_MODULUS;
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  // Input capture and exponent shifter
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      base_raw <= base;
      expo     <= exp_ext[EXP_BITS-1:0];
    end else if (cmd.exp_shift) begin
      expo <= expo >> 1;
    end
  end

  // Multiplier, registered product
  assign mul_a = (cmd.mul_sel == MUL_ACC_B) ? acc : b;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= MEXP_PROD_W'(mul_a) * MEXP_PROD_W'(b);
    end
  end

  // Shared remainder unit
  assign red_dividend = (cmd.red_src == RED_BASE) ?
                        {{(MEXP_PROD_W - MEXP_FIELD_W){1'b0}}, base_raw} : prod;

  mexp_modred u_modred (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.red_go),
    .dividend  (red_dividend),
    .modulus   (modulus),
    .done      (red_done),
    .remainder (rem)
  );

  // Running square of the base
  always_ff @(posedge clk) begin
    if (cmd.base_we) begin
      b <= rem;
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (cmd.acc_we) begin
      unique case (cmd.acc_src)
        ACC_ZERO: acc <= '0;
        ACC_ONE:  acc <= MEXP_MOD_W'(1);
        ACC_BASE: acc <= b;
        ACC_REM:  acc <= rem;
        default:  acc <= '0;
      endcase
    end
  end

  // Output data register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      power_mod <= acc;
    end
  end

  // Status to the controller
  always_comb begin
    status.mod_zero      = (modulus == '0);
    status.red_done      = red_done;
    status.base_le1      = (b[MEXP_MOD_W-1:1] == '0);
    status.exp_zero      = (expo == '0);
    status.exp_lsb       = expo[0];
    status.exp_rest_zero = ((expo >> 1) == '0);
  end

endmodule

// ----- rtl/core/mexp_ctrl.sv -----
// ---------------------------------------------------------------------------
// Modular exponentiation - controller
// Sequences base reduction, the special-case checks and the
// square-and-multiply loop; owns the stream handshakes.
// ---------------------------------------------------------------------------
module mexp_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mexp_pkg::mexp_status_t status,
  output mexp_pkg::mexp_cmd_t    cmd
);
  import mexp_pkg::*;

  mexp_state_t state;
  mexp_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid: set on load, cleared once the result is transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.mod_zero ? ST_DONE : ST_BASE_R;
        end
      end
      ST_BASE_R: state_next = ST_BASE_W;
      ST_BASE_W: begin
        if (status.red_done) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = status.base_le1 ? ST_DONE : ST_BIT;
      ST_BIT: begin
        priority if (status.exp_zero) begin
          state_next = ST_DONE;
        end else if (status.exp_lsb) begin
          state_next = ST_MUL_P;
        end else begin
          state_next = ST_SQR_P;
        end
      end
      ST_MUL_P: state_next = ST_MUL_R;
      ST_MUL_R: state_next = ST_MUL_W;
      ST_MUL_W: begin
        if (status.red_done) begin
          state_next = status.exp_rest_zero ? ST_DONE : ST_SQR_P;
        end
      end
      ST_SQR_P: state_next = ST_SQR_R;
      ST_SQR_R: state_next = ST_SQR_W;
      ST_SQR_W: begin
        if (status.red_done) begin
          state_next = ST_BIT;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        // zero modulus: result is zero, nothing to compute
        cmd.acc_we  = in_valid && status.mod_zero;
        cmd.acc_src = ACC_ZERO;
      end
      ST_BASE_R: begin
        cmd.red_go  = 1'b1;
        cmd.red_src = RED_BASE;
      end
      ST_BASE_W: cmd.base_we = status.red_done;
      ST_CHECK: begin
        // reduced base of zero or one is its own answer
        cmd.acc_we  = 1'b1;
        cmd.acc_src = status.base_le1 ? ACC_BASE : ACC_ONE;
      end
      ST_BIT: ;
      ST_MUL_P: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_ACC_B;
      end
      ST_MUL_R: begin
        cmd.red_go  = 1'b1;
        cmd.red_src = RED_PROD;
      end
      ST_MUL_W: begin
        cmd.acc_we  = status.red_done;
        cmd.acc_src = ACC_REM;
      end
      ST_SQR_P: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_B_B;
      end
      ST_SQR_R: begin
        cmd.red_go  = 1'b1;
        cmd.red_src = RED_PROD;
      end
      ST_SQR_W: begin
        cmd.base_we   = status.red_done;
        cmd.exp_shift = status.red_done;
      end
      ST_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/modular_exponentiation_unit.sv -----
// ---------------------------------------------------------------------------
// Modular exponentiation unit - top level
// base ** exponent mod modulus by right-to-left square-and-multiply.
//
//   Channel   Handshake                 Payload
//   s_axis    s_axis_tvalid/tready      tdata: base[62:0], exponent[125:63]
//   m_axis    m_axis_tvalid/tready      tdata: power_mod[31:0]
//   cfg       cfg_valid/cfg_ready       cfg_data: modulus[31:0]
//
// One item at a time. Base reduction and each modular multiply or square
// run through the bit-serial remainder unit (one dividend bit per cycle
// over a 64-bit product), so an item's run time grows with the position of
// the top set exponent bit and with the number of set exponent bits.
// Reset (rst, synchronous) loads modulus 1000000007 and empties the output.
// The next item is accepted while a finished result waits in the output
// register.
// ---------------------------------------------------------------------------
module modular_exponentiation_unit #(
  parameter int unsigned EXP_BITS = mexp_pkg::MEXP_EXP_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // base [62:0], exponent [125:63], zero [127:126]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [mexp_pkg::MEXP_IN_DATA_W-1:0]  s_axis_tdata,
  // power_mod [31:0]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [mexp_pkg::MEXP_OUT_DATA_W-1:0] m_axis_tdata,
  // modulus [31:0]
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mexp_pkg::MEXP_MOD_W-1:0]      cfg_data
);
  import mexp_pkg::*;

  mexp_cmd_t    cmd;
  mexp_status_t status;

  // Config writes are taken at once
  assign cfg_ready = 1'b1;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath #(
    .EXP_BITS (EXP_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .base      (s_axis_tdata[MEXP_FIELD_W-1:0]),
    .exponent  (s_axis_tdata[2*MEXP_FIELD_W-1:MEXP_FIELD_W]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .power_mod (m_axis_tdata)
  );

endmodule

// ----- rtl/core/mexp_checker.sv -----
// ---------------------------------------------------------------------------
// Modular exponentiation unit - port checker
// Watches the top-level ports: output stall behavior, single-item
// occupancy and range of the result against the written modulus.
// ---------------------------------------------------------------------------
`include "modular_exponentiation_unit_assert.svh"

module mexp_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 s_axis_tvalid,
  input logic                                 s_axis_tready,
  input logic                                 m_axis_tvalid,
  input logic                                 m_axis_tready,
  input logic [mexp_pkg::MEXP_OUT_DATA_W-1:0] m_axis_tdata,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [mexp_pkg::MEXP_MOD_W-1:0]      cfg_data
);
  import mexp_pkg::*;

  logic [MEXP_MOD_W-1:0] modulus_seen;

  // Track the modulus from config transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_seen <= MEXP_RESET_MODULUS;
    end else if (cfg_valid && cfg_ready) begin
      modulus_seen <= cfg_data;
    end
  end

  // A stalled result stays offered and unchanged
  `MEXP_ASSERT_NEXT(a_out_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `MEXP_ASSERT_NEXT(a_out_hold_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

  // Busy right after an input transfer
  `MEXP_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Results are fully reduced
  `MEXP_ASSERT_IMPL(a_result_reduced, m_axis_tvalid, (m_axis_tdata < modulus_seen) || (m_axis_tdata == '0))

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_data      (cfg_data)
);
